// ----- sv/vmm_pkg.sv -----
`default_nettype none

package vmm_pkg;

    // Field widths of the stream payloads.
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int ROW_IDX_W = 6;
    localparam int COL_IDX_W = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Input tdata: row_index, column_index, element_value, zero padded to bytes.
    localparam int S_ROW_LSB  = 0;
    localparam int S_COL_LSB  = S_ROW_LSB + ROW_IDX_W;
    localparam int S_VAL_LSB  = S_COL_LSB + COL_IDX_W;
    localparam int S_USED_W   = S_VAL_LSB + DATA_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Output tdata: product_value, result_column, zero padded to bytes.
    localparam int M_COL_LSB  = DATA_W;
    localparam int M_USED_W   = M_COL_LSB + COL_IDX_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // Input command codes; code 3 is unused and ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_WR_VECTOR = 2'd0,
        CMD_WR_MATRIX = 2'd1,
        CMD_COMPUTE   = 2'd2
    } cmd_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_RESET_VALUE   = 7'd64;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;
        logic issue;
        logic acc_clear;
        logic emit;
        logic last;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/vmm_ram.sv -----
`default_nettype none

module vmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/vmm_datapath.sv -----
`default_nettype none

module vmm_datapath #(
    parameter int MAX_LENGTH  = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire vmm_pkg::ctrl_t                       ctrl,
    output vmm_pkg::stat_t                            stat,
    input  wire logic [(((MAX_LENGTH < 64) ? MAX_LENGTH : 64) > 1 ?
                        $clog2((MAX_LENGTH < 64) ? MAX_LENGTH : 64) : 1)-1:0] row_idx,
    input  wire logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] col_idx,
    input  wire logic [vmm_pkg::CMD_W-1:0]            s_command,
    input  wire logic [vmm_pkg::ROW_IDX_W-1:0]        s_row,
    input  wire logic [vmm_pkg::COL_IDX_W-1:0]        s_col,
    input  wire logic [vmm_pkg::DATA_W-1:0]           s_value,
    input  wire logic                                 m_ready,
    output logic                                      m_valid,
    output logic      [vmm_pkg::DATA_W-1:0]           m_product,
    output logic      [vmm_pkg::COL_IDX_W-1:0]        m_column,
    output logic                                      m_last
);

    localparam int ROWS    = (MAX_LENGTH < 64) ? MAX_LENGTH : 64;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int M_DEPTH = ROWS * MAX_COLUMNS;
    localparam int M_AW    = (M_DEPTH > 1) ? $clog2(M_DEPTH) : 1;
    localparam int CALC_W  = vmm_pkg::ROW_IDX_W + vmm_pkg::COL_IDX_W + 1;

    logic                            wr_vec;
    logic                            wr_mat;
    logic [CALC_W-1:0]               wr_mat_full;
    logic [CALC_W-1:0]               rd_mat_full;
    logic [vmm_pkg::DATA_W-1:0]      vec_q;
    logic [vmm_pkg::DATA_W-1:0]      mat_q;
    logic [vmm_pkg::DATA_W-1:0]      prod_next;
    logic [vmm_pkg::DATA_W-1:0]      prod_reg;
    logic [vmm_pkg::DATA_W-1:0]      acc_reg;
    logic                            rd_valid_reg;
    logic                            mul_valid_reg;
    logic                            out_valid_reg;
    logic [vmm_pkg::DATA_W-1:0]      out_product_reg;
    logic [vmm_pkg::COL_IDX_W-1:0]   out_column_reg;
    logic                            out_last_reg;

    // Store write decode; writes outside the stores are dropped.
    always_comb begin
        wr_vec = 1'b0;
        wr_mat = 1'b0;
        if (ctrl.write && (32'(s_row) < 32'(MAX_LENGTH))) begin
            case (vmm_pkg::cmd_t'(s_command))
                vmm_pkg::CMD_WR_VECTOR: wr_vec = 1'b1;
                vmm_pkg::CMD_WR_MATRIX: wr_mat = (32'(s_col) < 32'(MAX_COLUMNS));
                default: ;
            endcase
        end
    end

    // Row-major matrix addresses.
    assign wr_mat_full = CALC_W'(s_row) * CALC_W'(MAX_COLUMNS) + CALC_W'(s_col);
    assign rd_mat_full = CALC_W'(row_idx) * CALC_W'(MAX_COLUMNS) + CALC_W'(col_idx);

    vmm_ram #(
        .WIDTH (vmm_pkg::DATA_W),
        .DEPTH (ROWS)
    ) u_vector_ram (
        .aclk    (aclk),
        .wr_en   (wr_vec),
        .wr_addr (s_row[ROW_W-1:0]),
        .wr_data (s_value),
        .rd_en   (ctrl.issue),
        .rd_addr (row_idx),
        .rd_data (vec_q)
    );

    vmm_ram #(
        .WIDTH (vmm_pkg::DATA_W),
        .DEPTH (M_DEPTH)
    ) u_matrix_ram (
        .aclk    (aclk),
        .wr_en   (wr_mat),
        .wr_addr (wr_mat_full[M_AW-1:0]),
        .wr_data (s_value),
        .rd_en   (ctrl.issue),
        .rd_addr (rd_mat_full[M_AW-1:0]),
        .rd_data (mat_q)
    );

    // Only the low word of the product matters, since sums wrap at 32 bits.
    assign prod_next = vec_q * mat_q;

    // Pipeline valid flags follow each read through multiply and accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= ctrl.issue;
            mul_valid_reg <= rd_valid_reg;
        end
    end

    // Product register and column accumulator.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (ctrl.acc_clear) begin
            acc_reg <= '0;
        end else if (mul_valid_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // Output register holds a finished result until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_product_reg <= acc_reg;
            out_column_reg  <= vmm_pkg::COL_IDX_W'(col_idx);
            out_last_reg    <= ctrl.last;
        end
    end

    assign stat.pipe_busy = rd_valid_reg | mul_valid_reg;
    assign stat.out_free  = !out_valid_reg | m_ready;

    assign m_valid   = out_valid_reg;
    assign m_product = out_product_reg;
    assign m_column  = out_column_reg;
    assign m_last    = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/vmm_controller.sv -----
`default_nettype none

module vmm_controller #(
    parameter int MAX_LENGTH  = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [vmm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [vmm_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [vmm_pkg::CMD_W-1:0]            s_command,
    input  wire vmm_pkg::stat_t                       stat,
    output vmm_pkg::ctrl_t                            ctrl,
    output logic [(((MAX_LENGTH < 64) ? MAX_LENGTH : 64) > 1 ?
                   $clog2((MAX_LENGTH < 64) ? MAX_LENGTH : 64) : 1)-1:0] row_idx,
    output logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] col_idx
);

    localparam int ROWS  = (MAX_LENGTH < 64) ? MAX_LENGTH : 64;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    vmm_pkg::state_t             state_reg;
    vmm_pkg::state_t             state_next;
    logic [vmm_pkg::CFG_W-1:0]   vector_length_reg;
    logic [vmm_pkg::CFG_W-1:0]   column_count_reg;
    logic [vmm_pkg::CFG_W-1:0]   len_eff;
    logic [vmm_pkg::CFG_W-1:0]   cols_eff;
    logic [ROW_W-1:0]            row_reg;
    logic [ROW_W-1:0]            row_next;
    logic [COL_W-1:0]            col_reg;
    logic [COL_W-1:0]            col_next;
    logic                        row_end;
    logic                        col_end;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_length_reg <= vmm_pkg::CFG_RESET_VALUE;
            column_count_reg  <= vmm_pkg::CFG_RESET_VALUE;
        end else if (cfg_valid) begin
            case (cfg_index)
                vmm_pkg::REG_VECTOR_LENGTH: vector_length_reg <= cfg_data;
                vmm_pkg::REG_COLUMN_COUNT:  column_count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero counts as one; larger values saturate at what the stores hold.
    always_comb begin
        if (vector_length_reg == '0) begin
            len_eff = 7'd1;
        end else if (32'(vector_length_reg) > 32'(ROWS)) begin
            len_eff = vmm_pkg::CFG_W'(ROWS);
        end else begin
            len_eff = vector_length_reg;
        end
        if (column_count_reg == '0) begin
            cols_eff = 7'd1;
        end else if (32'(column_count_reg) > 32'(MAX_COLUMNS)) begin
            cols_eff = vmm_pkg::CFG_W'(MAX_COLUMNS);
        end else begin
            cols_eff = column_count_reg;
        end
    end

    assign row_end = (vmm_pkg::CFG_W'(row_reg) == len_eff - 7'd1);
    assign col_end = (vmm_pkg::CFG_W'(col_reg) == cols_eff - 7'd1);

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vmm_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        s_ready        = 1'b0;
        ctrl.write     = 1'b0;
        ctrl.issue     = 1'b0;
        ctrl.acc_clear = 1'b0;
        ctrl.emit      = 1'b0;
        ctrl.last      = 1'b0;
        case (state_reg)
            vmm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (vmm_pkg::cmd_t'(s_command) == vmm_pkg::CMD_COMPUTE) begin
                        ctrl.acc_clear = 1'b1;
                        row_next       = '0;
                        col_next       = '0;
                        state_next     = vmm_pkg::ST_RUN;
                    end else begin
                        ctrl.write = 1'b1;
                    end
                end
            end
            vmm_pkg::ST_RUN: begin
                // One vector and one matrix read per cycle down the column.
                ctrl.issue = 1'b1;
                if (row_end) begin
                    row_next   = '0;
                    state_next = vmm_pkg::ST_DRAIN;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            vmm_pkg::ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = vmm_pkg::ST_EMIT;
                end
            end
            vmm_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    ctrl.emit = 1'b1;
                    ctrl.last = col_end;
                    if (col_end) begin
                        state_next = vmm_pkg::ST_IDLE;
                    end else begin
                        ctrl.acc_clear = 1'b1;
                        col_next       = col_reg + 1'b1;
                        state_next     = vmm_pkg::ST_RUN;
                    end
                end
            end
            default: begin
                state_next = vmm_pkg::ST_IDLE;
            end
        endcase
    end

    assign row_idx = row_reg;
    assign col_idx = col_reg;

endmodule

`default_nettype wire

// ----- sv/vector_matrix_multiply_top.sv -----
// Vector times matrix engine. Commands arrive on the input stream: a vector or
// matrix element write stores element_value at the given row (and column); writes
// stream at one per cycle while the engine is idle, and writes outside the stores
// and the unused command code are dropped. A compute command walks the columns
// in order and sends one result per column with its column number, tlast set on
// the final one, sums wrapping at 32 bits. A compute run is paced by the single
// multiply-accumulate unit fed by one read port on each store, plus any wait on
// the output; no new command is taken during the run. Entries must be written
// before a compute reads them. The user writes the two count registers through
// the configuration channel only while the engine is idle; the block does not
// enforce it. Zero counts as one, larger values saturate at the store size.
`default_nettype none

module vector_matrix_multiply_top #(
    parameter int MAX_LENGTH  = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration channel.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [vmm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [vmm_pkg::CFG_W-1:0]             cfg_data,
    // Command stream.
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: row_index [5:0], column_index [11:6], element_value [43:12], zeros
    input  wire logic [vmm_pkg::S_TDATA_W-1:0]         s_axis_tdata,
    // tuser: command [1:0]
    input  wire logic [vmm_pkg::CMD_W-1:0]             s_axis_tuser,
    // Result stream.
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata: product_value [31:0], result_column [37:32], zeros
    output logic      [vmm_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    output logic                                       m_axis_tlast
);

    localparam int ROWS  = (MAX_LENGTH < 64) ? MAX_LENGTH : 64;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    vmm_pkg::ctrl_t                  ctrl;
    vmm_pkg::stat_t                  stat;
    logic [ROW_W-1:0]                row_idx;
    logic [COL_W-1:0]                col_idx;
    logic [vmm_pkg::DATA_W-1:0]      m_product;
    logic [vmm_pkg::COL_IDX_W-1:0]   m_column;

    vmm_controller #(
        .MAX_LENGTH  (MAX_LENGTH),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_controller (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_command (s_axis_tuser),
        .stat      (stat),
        .ctrl      (ctrl),
        .row_idx   (row_idx),
        .col_idx   (col_idx)
    );

    vmm_datapath #(
        .MAX_LENGTH  (MAX_LENGTH),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .row_idx   (row_idx),
        .col_idx   (col_idx),
        .s_command (s_axis_tuser),
        .s_row     (s_axis_tdata[vmm_pkg::S_COL_LSB-1:vmm_pkg::S_ROW_LSB]),
        .s_col     (s_axis_tdata[vmm_pkg::S_VAL_LSB-1:vmm_pkg::S_COL_LSB]),
        .s_value   (s_axis_tdata[vmm_pkg::S_USED_W-1:vmm_pkg::S_VAL_LSB]),
        .m_ready   (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_product (m_product),
        .m_column  (m_column),
        .m_last    (m_axis_tlast)
    );

    // Pack the result fields, low field first, zero padded.
    assign m_axis_tdata = vmm_pkg::M_TDATA_W'({m_column, m_product});

endmodule

`default_nettype wire

// ----- sv/vmm_checker.sv -----
`default_nettype none

module vmm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [vmm_pkg::CMD_W-1:0]     s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [vmm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast
);

    logic                          s_compute;
    logic                          m_xfer;
    logic [1:0]                    runs_reg;
    logic [vmm_pkg::COL_IDX_W-1:0] exp_col_reg;

    assign s_compute = s_axis_tvalid && s_axis_tready &&
                       (vmm_pkg::cmd_t'(s_axis_tuser) == vmm_pkg::CMD_COMPUTE);
    assign m_xfer    = m_axis_tvalid && m_axis_tready;

    // Compute runs whose final result has not yet been transferred.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            runs_reg <= '0;
        end else if (s_compute && !(m_xfer && m_axis_tlast)) begin
            runs_reg <= runs_reg + 2'd1;
        end else if (!s_compute && m_xfer && m_axis_tlast) begin
            runs_reg <= runs_reg - 2'd1;
        end
    end

    // Column number expected on the next result transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_col_reg <= '0;
        end else if (m_xfer) begin
            exp_col_reg <= m_axis_tlast ? '0 : exp_col_reg + 1'b1;
        end
    end

    // A waiting result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Results come only from a compute run.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer |-> runs_reg != 2'd0)
        else $error("result without a compute command");

    // Columns are sent in order from zero.
    a_col_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer |-> m_axis_tdata[vmm_pkg::M_USED_W-1:vmm_pkg::M_COL_LSB] == exp_col_reg)
        else $error("result column out of order");

    // A new compute starts only once the previous run has finished computing.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_compute |-> runs_reg == 2'd0 || (m_axis_tvalid && m_axis_tlast && runs_reg == 2'd1))
        else $error("compute accepted during a run");

endmodule

bind vector_matrix_multiply_top vmm_checker u_vmm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
